// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define SDME_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define SDME_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/sdme_pkg.sv =====
// Types and constants for the switch debounce block.
// No dependencies; used by every module of the block.
package sdme_pkg;

    localparam int C_NUM_SWITCHES    = 8;
    localparam int C_PROBE_MS        = 10;
    localparam logic [7:0] C_CHAN_MASK = 8'((1 << C_NUM_SWITCHES) - 1);

    // request payloads
    typedef struct packed {
        logic       opcode;
        logic [7:0] raw_levels;
    } t_in;

    typedef struct packed {
        logic [2:0] channel;
        logic       level;
        logic [1:0] action;
        logic       last_event;
    } t_out;

    localparam logic C_OP_SAMPLE  = 1'b0;
    localparam logic C_OP_HANDLER = 1'b1;

    localparam logic [1:0] C_ACT_OFF    = 2'd0;
    localparam logic [1:0] C_ACT_ON     = 2'd1;
    localparam logic [1:0] C_ACT_TOGGLE = 2'd2;
    localparam logic [1:0] C_ACT_NONE   = 2'd3;

    localparam logic [2:0] C_MODE_TOGGLE      = 3'd0;
    localparam logic [2:0] C_MODE_FOLLOW      = 3'd1;
    localparam logic [2:0] C_MODE_FOLLOW_INV  = 3'd2;
    localparam logic [2:0] C_MODE_PUSH        = 3'd3;
    localparam logic [2:0] C_MODE_PUSH_INV    = 3'd4;
    localparam logic [2:0] C_MODE_HOLD        = 3'd5;
    localparam logic [2:0] C_MODE_HOLD_INV    = 3'd6;
    localparam logic [2:0] C_MODE_PUSH_TOGGLE = 3'd7;

    localparam logic [1:0] C_REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] C_REG_HOLD     = 2'd1;
    localparam logic [1:0] C_REG_ENABLE   = 2'd2;
    localparam logic [1:0] C_REG_MODE     = 2'd3;

    localparam int C_CFG_IDX_W  = 2;
    localparam int C_CFG_DATA_W = 24;

    // register defaults and the values derived from them
    localparam int C_DEBOUNCE_RST = 50;
    localparam int C_HOLD_RST     = 40;
    localparam int C_LOOP_NUM     = 1000;
    localparam int C_RST_FILT_RAW = C_DEBOUNCE_RST / C_PROBE_MS;
    localparam int C_RST_MOD      = C_DEBOUNCE_RST % 50;
    localparam int C_RST_LOOPS    = C_LOOP_NUM / C_DEBOUNCE_RST;
    localparam int C_RST_RLD_RAW  = C_RST_LOOPS * C_HOLD_RST / 10;
    localparam logic [7:0] C_RST_FILTER =
        8'((C_RST_FILT_RAW > 255) ? 255 : C_RST_FILT_RAW);
    localparam logic C_RST_FORCE_HI = 1'(C_RST_MOD & 1);
    localparam logic C_RST_FORCE_LO = 1'((C_RST_MOD >> 1) & 1);
    localparam logic [15:0] C_RST_RELOAD =
        16'((C_RST_RLD_RAW > 65535) ? 65535 : C_RST_RLD_RAW);

    // reciprocal constants for division by constants
    localparam int C_FILT_SHIFT = 20;
    localparam int C_RECIP_F_W  = 21;
    localparam logic [C_RECIP_F_W-1:0] C_RECIP_F =
        C_RECIP_F_W'(((1 << C_FILT_SHIFT) + C_PROBE_MS - 1) / C_PROBE_MS);
    localparam int C_Q50_SHIFT = 16;
    localparam logic [10:0] C_RECIP_50 = 11'(((1 << C_Q50_SHIFT) + 49) / 50);
    localparam int C_R10_SHIFT = 22;
    localparam logic [18:0] C_RECIP_10 = 19'(((1 << C_R10_SHIFT) + 9) / 10);

    typedef struct packed {
        logic        busy;
        logic [7:0]  filter;
        logic        snap_hi;
        logic        snap_lo;
        logic [15:0] reload;
        logic [7:0]  enable;
        logic [23:0] mode_table;
    } t_cfg;

    // one handler tick's changes
    typedef struct packed {
        logic [7:0]      mask;
        logic [7:0]      level;
        logic [7:0][1:0] action;
    } t_evt_rec;

    localparam int C_QUEUE_DEPTH = 4;

endpackage

// ===== rtl/core/switch_debounce_mode_events_top.sv =====
// A handler tick's record is queued, loaded into the back end, and its first
// result registered; results drain one per cycle unless the output stalls.
// One tick is accepted per cycle while the 4-record change queue has room and
// no register write or debounce_ms/hold_time recompute (10-step divider) runs.
// Synchronous active-low reset: registers to defaults, all channels released.
module switch_debounce_mode_events_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [sdme_pkg::C_CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sdme_pkg::C_CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  sdme_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output sdme_pkg::t_out                      o_out_data
);

    sdme_pkg::t_cfg     cfg;
    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    sdme_pkg::t_evt_rec q_wdata;
    sdme_pkg::t_evt_rec q_rdata;

    sdme_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    sdme_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_cfg       (cfg),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_wdata)
    );

    sdme_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    sdme_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_data    (q_rdata),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/core/sdme_cfg.sv =====
// Configuration registers and the derived debounce and hold values.
// Depends on sdme_pkg.
module sdme_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [sdme_pkg::C_CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sdme_pkg::C_CFG_DATA_W-1:0]   i_cfg_wdata,
    output sdme_pkg::t_cfg                      o_cfg
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MUL1 = 3'd3;
    localparam logic [2:0] S_MUL2 = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]  r_state;
    logic [9:0]  r_ms;
    logic [7:0]  r_hold;
    logic [7:0]  r_enable;
    logic [23:0] r_mode;
    logic [7:0]  r_filter;
    logic        r_force_hi;
    logic        r_force_lo;
    logic [15:0] r_reload;
    logic [3:0]  r_div_cnt;
    logic [9:0]  r_quo;
    logic [9:0]  r_rem;
    logic [sdme_pkg::C_RECIP_F_W+9:0] r_prod_f;
    logic [20:0] r_prod_q;
    logic [17:0] r_lp;
    logic [36:0] r_rp;

    logic [10:0] rem_sh;
    logic        div_ge;
    logic [9:0]  rem_nx;
    logic [10:0] filt_full;
    logic [4:0]  q50;
    logic [1:0]  m2;
    logic [9:0]  loops;

    always_comb begin
        rem_sh    = {r_rem, r_quo[9]};
        div_ge    = rem_sh >= {1'b0, r_ms};
        rem_nx    = div_ge ? 10'(rem_sh - {1'b0, r_ms}) : rem_sh[9:0];
        filt_full = r_prod_f[sdme_pkg::C_FILT_SHIFT +: 11];
        q50       = r_prod_q[sdme_pkg::C_Q50_SHIFT +: 5];
        m2        = 2'(r_ms[1:0] - {q50[0], 1'b0});
        loops     = (r_ms == 10'd0) ? 10'(sdme_pkg::C_LOOP_NUM) : r_quo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ms       <= 10'(sdme_pkg::C_DEBOUNCE_RST);
            r_hold     <= 8'(sdme_pkg::C_HOLD_RST);
            r_enable   <= '0;
            r_mode     <= '0;
            r_filter   <= sdme_pkg::C_RST_FILTER;
            r_force_hi <= sdme_pkg::C_RST_FORCE_HI;
            r_force_lo <= sdme_pkg::C_RST_FORCE_LO;
            r_reload   <= sdme_pkg::C_RST_RELOAD;
            r_div_cnt  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    sdme_pkg::C_REG_DEBOUNCE: begin
                        r_ms    <= i_cfg_wdata[9:0];
                        r_state <= S_INIT;
                    end
                    sdme_pkg::C_REG_HOLD: begin
                        r_hold  <= i_cfg_wdata[7:0];
                        r_state <= S_INIT;
                    end
                    sdme_pkg::C_REG_ENABLE: r_enable <= i_cfg_wdata[7:0];
                    sdme_pkg::C_REG_MODE:   r_mode   <= i_cfg_wdata[23:0];
                    default: ;
                endcase
            end else begin
                case (r_state)
                    S_INIT: begin
                        r_div_cnt <= 4'd10;
                        r_state   <= S_DIV;
                    end
                    S_DIV: begin
                        r_div_cnt <= r_div_cnt - 4'd1;
                        if (r_div_cnt == 4'd1) begin
                            r_state <= S_MUL1;
                        end
                    end
                    S_MUL1: begin
                        r_filter   <= (filt_full > 11'd255) ? 8'hFF : filt_full[7:0];
                        r_force_hi <= r_ms[0];
                        r_force_lo <= m2[1];
                        r_state    <= S_MUL2;
                    end
                    S_MUL2: r_state <= S_DONE;
                    S_DONE: begin
                        // at most 25500, so the 65535 ceiling never bites
                        r_reload <= 16'(r_rp[sdme_pkg::C_R10_SHIFT +: 15]);
                        r_state  <= S_IDLE;
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    // datapath, no reset; holds while a register is written
    always_ff @(posedge i_clk) begin
        if (!i_cfg_wr_en) begin
            case (r_state)
                S_INIT: begin
                    r_prod_f <= (sdme_pkg::C_RECIP_F_W+10)'(r_ms)
                              * (sdme_pkg::C_RECIP_F_W+10)'(sdme_pkg::C_RECIP_F);
                    r_prod_q <= 21'(r_ms) * 21'(sdme_pkg::C_RECIP_50);
                    r_rem    <= '0;
                    r_quo    <= 10'(sdme_pkg::C_LOOP_NUM);
                end
                S_DIV: begin
                    r_rem <= rem_nx;
                    r_quo <= {r_quo[8:0], div_ge};
                end
                S_MUL1: r_lp <= 18'(loops) * 18'(r_hold);
                S_MUL2: r_rp <= 37'(r_lp) * 37'(sdme_pkg::C_RECIP_10);
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.busy       = (r_state != S_IDLE);
        o_cfg.filter     = r_filter;
        o_cfg.snap_hi    = r_force_hi;
        o_cfg.snap_lo    = r_force_lo;
        o_cfg.reload     = r_reload;
        o_cfg.enable     = r_enable & sdme_pkg::C_CHAN_MASK;
        o_cfg.mode_table = r_mode;
    end

endmodule

// ===== rtl/core/sdme_front.sv =====
// Front end: accepts ticks, runs the debounce counters and hold
// timers, and records each handler tick's changes. Depends on sdme_pkg.
module sdme_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sdme_pkg::t_in       i_in_data,
    input  sdme_pkg::t_cfg      i_cfg,
    input  logic                i_cfg_wr_en,
    input  logic                i_q_full,
    output logic                o_q_push,
    output sdme_pkg::t_evt_rec  o_q_data
);

    typedef struct packed {
        logic [7:0] cnt;
        logic       lvl;
    } t_lane_s;

    typedef struct packed {
        logic [15:0] hold;
        logic [1:0]  act;
    } t_lane_h;

    logic [7:0]       r_cnt [8];
    logic [7:0]       r_lvl;
    logic [7:0]       r_prev;
    logic [15:0]      r_hold [8];

    t_lane_s          lane_s [8];
    t_lane_h          lane_h [8];
    logic [7:0]       chg;
    logic             accept;

    function automatic t_lane_s f_sample(input logic [7:0] cnt, input logic lvl,
                                         input logic raw, input sdme_pkg::t_cfg cfg);
        t_lane_s    res;
        logic [7:0] base;
        logic [7:0] step;
        begin
            res.cnt = cnt;
            res.lvl = lvl;
            if (raw) begin
                base    = (cfg.snap_hi && lvl) ? cfg.filter : cnt;
                step    = 8'(base + 8'd1);
                res.cnt = base;
                if (base < cfg.filter) begin
                    res.cnt = step;
                    if (step == cfg.filter) begin
                        res.lvl = 1'b1;
                    end
                end
            end else begin
                base    = (cfg.snap_lo && !lvl) ? 8'd0 : cnt;
                step    = 8'(base - 8'd1);
                res.cnt = base;
                if (base != 8'd0) begin
                    res.cnt = step;
                    if (step == 8'd0) begin
                        res.lvl = 1'b0;
                    end
                end
            end
            return res;
        end
    endfunction

    function automatic t_lane_h f_handle(input logic [15:0] hold, input logic lvl,
                                         input logic changed, input logic [2:0] mode,
                                         input logic [15:0] reload);
        t_lane_h     res;
        logic [15:0] hd;
        logic        press;
        begin
            hd       = (hold != 16'd0) ? 16'(hold - 16'd1) : hold;
            press    = (mode == sdme_pkg::C_MODE_HOLD_INV);
            res.hold = hd;
            res.act  = sdme_pkg::C_ACT_NONE;
            if (changed) begin
                case (mode)
                    sdme_pkg::C_MODE_TOGGLE:     res.act = sdme_pkg::C_ACT_TOGGLE;
                    sdme_pkg::C_MODE_FOLLOW:
                        res.act = lvl ? sdme_pkg::C_ACT_ON : sdme_pkg::C_ACT_OFF;
                    sdme_pkg::C_MODE_FOLLOW_INV:
                        res.act = lvl ? sdme_pkg::C_ACT_OFF : sdme_pkg::C_ACT_ON;
                    sdme_pkg::C_MODE_PUSH:
                        res.act = lvl ? sdme_pkg::C_ACT_NONE : sdme_pkg::C_ACT_TOGGLE;
                    sdme_pkg::C_MODE_PUSH_INV:
                        res.act = lvl ? sdme_pkg::C_ACT_TOGGLE : sdme_pkg::C_ACT_NONE;
                    sdme_pkg::C_MODE_HOLD, sdme_pkg::C_MODE_HOLD_INV: begin
                        if (lvl == press) begin
                            res.hold = reload;
                        end else if (hd != 16'd0) begin
                            res.hold = 16'd0;
                            res.act  = sdme_pkg::C_ACT_TOGGLE;
                        end
                    end
                    default: res.act = sdme_pkg::C_ACT_TOGGLE;
                endcase
            end
            return res;
        end
    endfunction

    assign o_in_stall = i_cfg.busy || i_cfg_wr_en || i_q_full;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            chg[i]    = i_cfg.enable[i] && (r_lvl[i] != r_prev[i]);
            lane_s[i] = f_sample(r_cnt[i], r_lvl[i], i_in_data.raw_levels[i], i_cfg);
            lane_h[i] = f_handle(r_hold[i], r_lvl[i], chg[i],
                                 i_cfg.mode_table[3*i +: 3], i_cfg.reload);
            o_q_data.action[i] = lane_h[i].act;
        end
        o_q_data.mask  = chg;
        o_q_data.level = r_lvl;
        o_q_push = accept && (i_in_data.opcode == sdme_pkg::C_OP_HANDLER) && (chg != 8'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_cnt[i]  <= '0;
                r_hold[i] <= '0;
            end
            r_lvl  <= '1;
            r_prev <= '1;
        end else if (accept) begin
            for (int i = 0; i < 8; i++) begin
                if (i_cfg.enable[i]) begin
                    if (i_in_data.opcode == sdme_pkg::C_OP_SAMPLE) begin
                        r_cnt[i] <= lane_s[i].cnt;
                        r_lvl[i] <= lane_s[i].lvl;
                    end else begin
                        r_hold[i] <= lane_h[i].hold;
                        r_prev[i] <= r_lvl[i];
                    end
                end
            end
        end
    end

endmodule

// ===== rtl/core/sdme_queue.sv =====
// Small FIFO of change records between the front and back ends.
// Depends on sdme_pkg.
module sdme_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sdme_pkg::t_evt_rec  i_data,
    output logic                o_full,
    input  logic                i_pop,
    output sdme_pkg::t_evt_rec  o_data,
    output logic                o_empty
);

    localparam int PW = $clog2(sdme_pkg::C_QUEUE_DEPTH);

    sdme_pkg::t_evt_rec r_mem [sdme_pkg::C_QUEUE_DEPTH];
    logic [PW-1:0]      r_wr;
    logic [PW-1:0]      r_rd;
    logic [PW:0]        r_count;

    assign o_full  = (r_count == (PW+1)'(sdme_pkg::C_QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= PW'(r_wr + 1'b1);
            end
            if (i_pop) begin
                r_rd <= PW'(r_rd + 1'b1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/core/sdme_back.sv =====
// Back end: walks a change record channel by channel and drives the
// registered result request. Depends on sdme_pkg.
module sdme_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  sdme_pkg::t_evt_rec  i_q_data,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sdme_pkg::t_out      o_out_data
);

    logic               r_have;
    sdme_pkg::t_evt_rec r_rec;
    logic               r_out_valid;
    sdme_pkg::t_out     r_out;

    logic [2:0]         pick;
    logic [7:0]         rest;
    logic               last;
    logic               adv;

    always_comb begin
        pick = '0;
        for (int i = 7; i >= 0; i--) begin
            if (r_rec.mask[i]) begin
                pick = 3'(i);
            end
        end
        rest    = r_rec.mask & 8'(r_rec.mask - 8'd1);
        last    = (rest == 8'd0);
        adv     = r_have && (!r_out_valid || !i_out_stall);
        o_q_pop = !i_q_empty && (!r_have || (adv && last));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_have <= 1'b1;
            end else if (adv && last) begin
                r_have <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rec <= i_q_data;
        end else if (adv) begin
            r_rec.mask <= rest;
        end
        if (adv) begin
            r_out.channel    <= pick;
            r_out.level      <= r_rec.level[pick];
            r_out.action     <= r_rec.action[pick];
            r_out.last_event <= last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/core/sdme_checker.sv =====
// Port-level checks for the switch debounce top level, bound to it below.
// Depends on sdme_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sdme_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_cfg_wr_en,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input sdme_pkg::t_out o_out_data
);

    property p_out_hold;
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data);
    endproperty

    property p_rst_quiet;
        !i_rst_n |=> !o_out_valid;
    endproperty

    property p_cfg_stall;
        i_cfg_wr_en |-> o_in_stall;
    endproperty

    property p_chan_order;
        o_out_valid && !i_out_stall && !o_out_data.last_event |=>
            o_out_valid && (o_out_data.channel > $past(o_out_data.channel));
    endproperty

    `SDME_ASSERT(a_out_hold, i_clk, i_rst_n, p_out_hold, "stalled result request changed")
    `SDME_ASSERT_ALWAYS(a_rst_quiet, i_clk, p_rst_quiet, "result request right after reset")
    `SDME_ASSERT(a_cfg_stall, i_clk, i_rst_n, p_cfg_stall, "input taken during a register write")
    `SDME_ASSERT(a_chan_order, i_clk, i_rst_n, p_chan_order, "tick results out of channel order")

endmodule

bind switch_debounce_mode_events_top sdme_checker u_sdme_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_wr_en (i_cfg_wr_en),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
